>>> hdl/warp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// warp_pkg: shared types and constants
// Geometry limits, transaction structs and the front-to-back queue entry.
// ---------------------------------------------------------------------------
package warp_pkg;
  localparam int MAX_OBS     = 64;
  localparam int MAX_GOODS   = 16;
  localparam int VALUE_BITS  = 16;
  localparam int STORE_DEPTH = MAX_OBS * MAX_GOODS;
  localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
  localparam int POS_BITS    = $clog2(STORE_DEPTH + 1);
  localparam int OBS_BITS    = 7;
  localparam int GOODS_BITS  = 5;
  localparam int IDX_BITS    = $clog2(MAX_OBS);
  localparam int COL_BITS    = $clog2(MAX_GOODS + 1);
  localparam int PROD_BITS   = 2 * VALUE_BITS;
  localparam int ACC_BITS    = PROD_BITS + $clog2(MAX_GOODS + 1);
  localparam int CFG_BITS    = 7;

  localparam logic CFG_OBS   = 1'b0;
  localparam logic CFG_GOODS = 1'b1;

  typedef struct packed {
    logic [15:0] price;
    logic [15:0] quantity;
    logic        last_entry;
  } in_item_t;

  typedef struct packed {
    logic       violation;
    logic [6:0] first_violator;
    logic [6:0] second_violator;
    logic       load_overflow;
  } out_item_t;

  // scan job handed from the loader to the scanner
  typedef struct packed {
    logic                  overflow;
    logic [OBS_BITS-1:0]   n;
    logic [GOODS_BITS-1:0] g;
  } job_t;
endpackage

>>> hdl/warp_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// warp_ram: generic simple dual-port RAM
// One write and one read per cycle, registered read data.
// ---------------------------------------------------------------------------
module warp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/warp_loader.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// warp_loader: entry loader
// Writes entries into the stores, tracks overflow and queues a scan job.
// ---------------------------------------------------------------------------
module warp_loader import warp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  input  logic [OBS_BITS-1:0]   obs_r,
  input  logic [GOODS_BITS-1:0] goods_r,
  input  logic                  scan_busy,
  output logic                  we,
  output logic [ADDR_BITS-1:0]  waddr,
  output logic                  job_valid,
  input  logic                  job_ready,
  output job_t                  job
);
  logic [POS_BITS-1:0]   pos_r, pos_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  jv_r, jv_nxt;
  job_t                  job_r, job_nxt;
  logic [OBS_BITS-1:0]   n;
  logic [GOODS_BITS-1:0] g;
  logic [POS_BITS+1:0]   cap;
  logic                  fire, fits;

  // clamp geometry
  assign n    = (obs_r > OBS_BITS'(MAX_OBS)) ? OBS_BITS'(MAX_OBS) : obs_r;
  assign g    = (goods_r > GOODS_BITS'(MAX_GOODS)) ? GOODS_BITS'(MAX_GOODS) : goods_r;
  assign cap  = (POS_BITS+2)'(n * g);
  // stores stay untouched while a job waits or the scanner still reads them
  assign in_ready  = !jv_r && !scan_busy;
  assign fire = in_valid && in_ready;
  assign fits = ((POS_BITS+2)'(pos_r) < cap);
  assign we    = fire && fits;
  assign waddr = pos_r[ADDR_BITS-1:0];
  assign job_valid = jv_r;
  assign job       = job_r;

  always_comb begin
    pos_nxt = pos_r;
    ovf_nxt = ovf_r;
    jv_nxt  = jv_r && !job_ready;
    job_nxt = job_r;
    if (fire) begin
      if (fits) pos_nxt = pos_r + 1'b1;
      else ovf_nxt = 1'b1;
      if (in_data.last_entry) begin
        jv_nxt  = 1'b1;
        job_nxt = '{overflow: ovf_r || !fits, n: n, g: g};
        pos_nxt = '0;
        ovf_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ovf_r <= 1'b0;
      jv_r  <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      ovf_r <= ovf_nxt;
      jv_r  <= jv_nxt;
    end
    job_r <= job_nxt;
  end
endmodule

>>> hdl/warp_scanner.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// warp_scanner: pairwise scan engine
// Walks pairs i<k, streaming one good of both rows at a time (RDI, RDK, MUL,
// ACC) through the store, accumulating four dot products, and emits the first
// violation, or a result without one when no pair violates.
module warp_scanner import warp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_valid,
  output logic                 job_ready,
  input  job_t                 job,
  output logic                 scan_busy,
  output logic [ADDR_BITS-1:0] raddr,
  input  logic [15:0]          p_rd,
  input  logic [15:0]          x_rd,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDI   = 3'd1;
  localparam logic [2:0] S_RDK   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_ACC   = 3'd4;
  localparam logic [2:0] S_CMP   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]            st_r, st_nxt;
  job_t                  job_r, job_nxt;
  logic [OBS_BITS-1:0]   i_r, i_nxt, k_r, k_nxt;
  logic [COL_BITS-1:0]   c_r, c_nxt;
  logic [15:0]           pi_r, pi_nxt, xi_r, xi_nxt;
  logic [PROD_BITS-1:0]  m0_r, m1_r, m2_r, m3_r;
  logic [15:0]           xk_r;
  logic [ACC_BITS-1:0]   a0_r, a1_r, a2_r, a3_r;
  logic [ACC_BITS-1:0]   a0_nxt, a1_nxt, a2_nxt, a3_nxt;
  logic                  d_r, d_nxt;
  out_item_t             res_r, res_nxt;
  logic [OBS_BITS+GOODS_BITS:0] base;
  logic                  hit;

  assign job_ready = (st_r == S_IDLE);
  assign scan_busy = (st_r != S_IDLE) && (st_r != S_OUT);
  assign out_valid = (st_r == S_OUT);
  assign out_data  = res_r;
  assign hit = (a0_r >= a1_r) && (a2_r >= a3_r) && d_r;

  // address of current good in row i or row k
  always_comb begin
    base = (st_r == S_RDI) ? (OBS_BITS+GOODS_BITS+1)'(i_r * job_r.g)
                           : (OBS_BITS+GOODS_BITS+1)'(k_r * job_r.g);
    raddr = ADDR_BITS'(base + (OBS_BITS+GOODS_BITS+1)'(c_r));
  end

  always_comb begin
    st_nxt = st_r; job_nxt = job_r; i_nxt = i_r; k_nxt = k_r; c_nxt = c_r;
    pi_nxt = pi_r; xi_nxt = xi_r;
    a0_nxt = a0_r; a1_nxt = a1_r; a2_nxt = a2_r; a3_nxt = a3_r;
    d_nxt = d_r; res_nxt = res_r;
    case (st_r)
      S_IDLE: begin
        if (job_valid) begin
          job_nxt = job;
          i_nxt = '0; k_nxt = OBS_BITS'(1); c_nxt = '0;
          a0_nxt = '0; a1_nxt = '0; a2_nxt = '0; a3_nxt = '0; d_nxt = 1'b0;
          res_nxt = '{violation: 1'b0, first_violator: '0, second_violator: '0,
                      load_overflow: job.overflow};
          st_nxt = (job.n < OBS_BITS'(2) || job.g == '0) ? S_OUT : S_RDI;
        end
      end
      S_RDI: st_nxt = S_RDK;
      S_RDK: begin
        pi_nxt = p_rd; xi_nxt = x_rd;
        st_nxt = S_MUL;
      end
      S_MUL: st_nxt = S_ACC;
      S_ACC: begin
        a0_nxt = a0_r + ACC_BITS'(m0_r);
        a1_nxt = a1_r + ACC_BITS'(m1_r);
        a2_nxt = a2_r + ACC_BITS'(m2_r);
        a3_nxt = a3_r + ACC_BITS'(m3_r);
        if (xi_r != xk_r) d_nxt = 1'b1;
        if (c_r + 1'b1 == COL_BITS'(job_r.g)) begin
          st_nxt = S_CMP;
        end else begin
          c_nxt = c_r + 1'b1;
          st_nxt = S_RDI;
        end
      end
      S_CMP: begin
        c_nxt = '0;
        a0_nxt = '0; a1_nxt = '0; a2_nxt = '0; a3_nxt = '0; d_nxt = 1'b0;
        if (hit) begin
          res_nxt.violation = 1'b1;
          res_nxt.first_violator  = i_r + 1'b1;
          res_nxt.second_violator = k_r + 1'b1;
          st_nxt = S_OUT;
        end else if (k_r + 1'b1 < job_r.n) begin
          k_nxt = k_r + 1'b1;
          st_nxt = S_RDI;
        end else if (i_r + OBS_BITS'(2) < job_r.n) begin
          i_nxt = i_r + 1'b1;
          k_nxt = i_r + OBS_BITS'(2);
          st_nxt = S_RDI;
        end else begin
          st_nxt = S_OUT;
        end
      end
      S_OUT: if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // products registered once the k entry is in
  always_ff @(posedge clk) begin
    if (st_r == S_MUL) begin
      m0_r <= pi_r * xi_r;
      m1_r <= pi_r * x_rd;
      m2_r <= p_rd * x_rd;
      m3_r <= p_rd * xi_r;
      xk_r <= x_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
    job_r <= job_nxt; i_r <= i_nxt; k_r <= k_nxt; c_r <= c_nxt;
    pi_r <= pi_nxt; xi_r <= xi_nxt;
    a0_r <= a0_nxt; a1_r <= a1_nxt; a2_r <= a2_nxt; a3_r <= a3_nxt;
    d_r <= d_nxt; res_r <= res_nxt;
  end
endmodule

>>> hdl/warp_pairwise_violation_check.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// warp_pairwise_violation_check: revealed preference pair checker
// Loads price/quantity matrices and reports the first violating pair.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one (price, quantity) entry per transaction, row-major. Loading
//           takes one entry per cycle while in_ready is high. The entry with
//           last_entry set closes the load and queues a scan job.
//   out_* : one transaction per load with the violation flag, the 1-based
//           pair indices (zero if none) and the overflow flag.
//   cfg_* : obs_count (index 0) and goods_count (index 1), written idle.
//   Scan: after the closing entry is taken, the scanner examines pairs up
//   to the first violation (at most n*(n-1)/2, none when n < 2 or g = 0).
//   Each good takes four steps: two reads through the single read port,
//   product, accumulate.
//   The input stalls from the closing entry until the scan finishes, so the
//   stores never change under a running scan; the next load may start while
//   the result waits. A stalled receiver holds the result and keeps the
//   scanner from taking the next job, which stalls the input again.
//   Reset (synchronous, rst_n low) clears control state and geometry to
//   64 by 16; store contents stay undefined until written.
// ---------------------------------------------------------------------------
module warp_pairwise_violation_check import warp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data
);
  logic [OBS_BITS-1:0]   obs_r;
  logic [GOODS_BITS-1:0] goods_r;
  logic                  we, job_valid, job_ready, scan_busy;
  logic [ADDR_BITS-1:0]  waddr, raddr;
  job_t                  job;
  logic [15:0]           p_rd, x_rd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obs_r   <= OBS_BITS'(64);
      goods_r <= GOODS_BITS'(16);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OBS:   obs_r   <= cfg_data[OBS_BITS-1:0];
        CFG_GOODS: goods_r <= cfg_data[GOODS_BITS-1:0];
        default: ;
      endcase
    end
  end

  warp_loader u_load (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .obs_r, .goods_r,
    .scan_busy, .we, .waddr, .job_valid, .job_ready, .job
  );

  warp_ram #(.WIDTH(16), .DEPTH(STORE_DEPTH)) u_price (
    .clk, .we, .waddr, .wdata(in_data.price), .raddr, .rdata(p_rd)
  );
  warp_ram #(.WIDTH(16), .DEPTH(STORE_DEPTH)) u_qty (
    .clk, .we, .waddr, .wdata(in_data.quantity), .raddr, .rdata(x_rd)
  );

  warp_scanner u_scan (
    .clk, .rst_n, .job_valid, .job_ready, .job, .scan_busy, .raddr, .p_rd, .x_rd,
    .out_valid, .out_ready, .out_data
  );
endmodule

>>> hdl/warp_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// warp_checker: port-level checks
// Watches result consistency and output handshake at the top level.
// ---------------------------------------------------------------------------
module warp_checker import warp_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);
  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  // no violation means zero indices
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.violation |->
      out_data.first_violator == '0 && out_data.second_violator == '0)
    else $error("indices without violation");
  // pair ordering
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.violation |->
      out_data.first_violator < out_data.second_violator &&
      out_data.first_violator != '0)
    else $error("bad pair order");
endmodule

bind warp_pairwise_violation_check warp_checker u_chk (
  .clk, .rst_n, .out_valid, .out_ready, .out_data
);

>>> tb/sv/tb_warp_pairwise_violation_check.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_warp_pairwise_violation_check: self-checking bench for the pair checker
// Loads price/quantity matrices under many geometries and compares every
// result transaction against a cycle-free model of the pairwise scan.
// ---------------------------------------------------------------------------
module tb_warp_pairwise_violation_check;
  import warp_pkg::*;

  localparam int IDLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 3000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = CFG_OBS;
  logic [CFG_BITS-1:0] cfg_data = '0;

  warp_pairwise_violation_check dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // matrix model state
  int unsigned obs_reg = 64;
  int unsigned goods_reg = 16;
  logic [15:0] price_mem [STORE_DEPTH];
  logic [15:0] qty_mem [STORE_DEPTH];
  int unsigned fill_pos = 0;
  bit dropped_seen = 1'b0;
  bit ever_written [STORE_DEPTH];

  in_item_t entry_q [$];
  out_item_t verdict_q [$];
  int errors = 0;
  int queued_items = 0;
  bit hold_req = 1'b0;

  function automatic int unsigned rows_used();
    return (obs_reg > MAX_OBS) ? MAX_OBS : obs_reg;
  endfunction

  function automatic int unsigned cols_used();
    return (goods_reg > MAX_GOODS) ? MAX_GOODS : goods_reg;
  endfunction

  // store one entry; on the closing entry, scan pairs for the first violation
  function automatic void absorb_entry(input in_item_t it);
    int unsigned n, g, ai, ak;
    longint unsigned s_ii, s_ik, s_kk, s_ki;
    bit differ, found;
    out_item_t v;
    n = rows_used();
    g = cols_used();
    if (fill_pos < n * g) begin
      price_mem[fill_pos] = it.price;
      qty_mem[fill_pos] = it.quantity;
      fill_pos++;
    end else begin
      dropped_seen = 1'b1;
    end
    if (!it.last_entry) return;
    v = '0;
    found = 1'b0;
    for (int i = 0; i < n && !found; i++) begin
      for (int k = i + 1; k < n && !found; k++) begin
        s_ii = 0; s_ik = 0; s_kk = 0; s_ki = 0;
        differ = 1'b0;
        for (int c = 0; c < g; c++) begin
          ai = i * g + c;
          ak = k * g + c;
          s_ii += longint'(price_mem[ai]) * qty_mem[ai];
          s_ik += longint'(price_mem[ai]) * qty_mem[ak];
          s_kk += longint'(price_mem[ak]) * qty_mem[ak];
          s_ki += longint'(price_mem[ak]) * qty_mem[ai];
          if (qty_mem[ai] != qty_mem[ak]) differ = 1'b1;
        end
        if (s_ii >= s_ik && s_kk >= s_ki && differ) begin
          found = 1'b1;
          v.violation = 1'b1;
          v.first_violator = 7'(i + 1);
          v.second_violator = 7'(k + 1);
        end
      end
    end
    v.load_overflow = dropped_seen;
    verdict_q.push_back(v);
    fill_pos = 0;
    dropped_seen = 1'b0;
  endfunction

  task automatic report(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    errors++;
  endtask

  // driver: bursts of transactions separated by random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    logic nv;
    nv = in_valid;
    if (!rst_n) begin
      nv = 1'b0;
    end else if (!in_valid || in_ready) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (entry_q.size() != 0) begin
        in_data <= entry_q.pop_front();
        nv = 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
    in_valid <= nv;
  end

  // receiver: randomly chosen stall patterns, plus a long hold-off
  int rx_mode = 0;
  int rx_tick = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    logic nr;
    nr = 1'b0;
    rx_tick <= rx_tick + 1;
    if (rx_tick % 64 == 0) rx_mode <= $urandom_range(0, 2);
    if (hold_req && hold_left == 0) begin
      hold_left <= HOLD_CYCLES;
      hold_req = 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (rst_n) begin
      case (rx_mode)
        0: nr = 1'b1;
        1: nr = $urandom_range(0, 1);
        default: nr = ($urandom_range(0, 3) == 0);
      endcase
    end
    out_ready <= nr;
  end

  // monitor: predict on accepted inputs, check accepted results
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && in_valid && in_ready) absorb_entry(in_data);
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        report($sformatf("unexpected result %p", out_data));
      end else begin
        want = verdict_q.pop_front();
        if (out_data.violation !== want.violation)
          report($sformatf("violation %b want %b", out_data.violation, want.violation));
        if (out_data.first_violator !== want.first_violator)
          report($sformatf("first_violator %0d want %0d",
                           out_data.first_violator, want.first_violator));
        if (out_data.second_violator !== want.second_violator)
          report($sformatf("second_violator %0d want %0d",
                           out_data.second_violator, want.second_violator));
        if (out_data.load_overflow !== want.load_overflow)
          report($sformatf("load_overflow %b want %b",
                           out_data.load_overflow, want.load_overflow));
      end
    end
  end

  // watchdog on cycles without any transaction
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (entry_q.size() != 0 || in_valid || verdict_q.size() != 0);
  endtask

  task automatic write_reg(input logic [0:0] idx, input int unsigned val);
    wait_drained();
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_BITS'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_OBS) obs_reg = val & 7'h7f;
    else goods_reg = val & 5'h1f;
  endtask

  task automatic set_geometry(input int unsigned n, input int unsigned g);
    write_reg(CFG_OBS, n);
    write_reg(CFG_GOODS, g);
  endtask

  function automatic logic [15:0] pick_value(input int style);
    if (style == 1) begin
      case ($urandom_range(0, 4))
        0: return 16'h0000;
        1: return 16'hffff;
        2: return 16'h0100;
        3: return 16'(1 << $urandom_range(0, 15));
        default: return 16'($urandom_range(0, 3));
      endcase
    end
    return 16'($urandom);
  endfunction

  // queue one load of len entries; style 0 random, 1 corner values,
  // 2 shared bundles with a single odd row
  task automatic queue_load(input int len, input int style);
    int unsigned n, g, row, col, odd;
    logic [15:0] shared_q [MAX_GOODS];
    logic [15:0] row_p;
    in_item_t it;
    n = rows_used();
    g = cols_used();
    odd = (n > 0) ? $urandom_range(0, n - 1) : 0;
    for (int c = 0; c < MAX_GOODS; c++) shared_q[c] = pick_value(1);
    row_p = pick_value(0);
    for (int p = 0; p < len; p++) begin
      row = (g != 0) ? p / g : 0;
      col = (g != 0) ? p % g : 0;
      if (col == 0) row_p = pick_value($urandom_range(0, 1));
      if (style == 2) begin
        it.price = ($urandom_range(0, 1) != 0) ? row_p : pick_value(0);
        it.quantity = (row == odd && col == 0) ? pick_value(0) : shared_q[col];
      end else begin
        it.price = pick_value(style);
        it.quantity = pick_value(style);
      end
      it.last_entry = (p == len - 1);
      if (p < n * g && p < STORE_DEPTH) ever_written[p] = 1'b1;
      entry_q.push_back(it);
      queued_items++;
    end
  endtask

  // one load with full, overflowing or (where safe) short length
  task automatic run_load(input int style);
    int unsigned cap, len, k;
    bit short_ok;
    cap = rows_used() * cols_used();
    k = $urandom_range(0, 9);
    if (cap == 0) begin
      len = $urandom_range(1, 3);
    end else if (k == 0) begin
      len = cap + $urandom_range(1, 3);
    end else if (k == 1 && cap > 1) begin
      len = $urandom_range(1, cap - 1);
      short_ok = 1'b1;
      for (int p = len; p < cap; p++) if (!ever_written[p]) short_ok = 1'b0;
      if (!short_ok) len = cap;
    end else begin
      len = cap;
    end
    queue_load(len, style);
    wait_drained();
  endtask

  initial begin
    in_item_t it;
    for (int p = 0; p < STORE_DEPTH; p++) ever_written[p] = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: two rows, one good, extreme values
    set_geometry(2, 1);
    it = '{price: 16'hffff, quantity: 16'hffff, last_entry: 1'b0};
    entry_q.push_back(it);
    it = '{price: 16'h0000, quantity: 16'h0000, last_entry: 1'b1};
    entry_q.push_back(it);
    it = '{price: 16'h0000, quantity: 16'hffff, last_entry: 1'b0};
    entry_q.push_back(it);
    it = '{price: 16'hffff, quantity: 16'h0000, last_entry: 1'b1};
    entry_q.push_back(it);
    ever_written[0] = 1'b1;
    ever_written[1] = 1'b1;
    wait_drained();
    // short load reuses a row written earlier
    it = '{price: 16'h0100, quantity: 16'h0001, last_entry: 1'b1};
    entry_q.push_back(it);
    wait_drained();
    // no rows: everything dropped
    set_geometry(0, 4);
    queue_load(2, 0);
    wait_drained();
    // no goods: everything dropped, no violation reported
    set_geometry(3, 0);
    queue_load(1, 1);
    wait_drained();
    // single row, no pair; then an overflowing load
    set_geometry(1, 2);
    queue_load(2, 1);
    queue_load(3, 0);
    wait_drained();
    // shared bundles with a single odd row
    set_geometry(3, 2);
    queue_load(6, 2);
    wait_drained();

    // back-pressure: identical loads while the receiver holds off
    set_geometry(3, 2);
    queue_load(6, 1);
    for (int r = 0; r < 3; r++)
      for (int p = 0; p < 6; p++) begin
        entry_q.push_back(entry_q[p]);
        queued_items++;
      end
    hold_req = 1'b1;
    wait_drained();

    // random loads, mostly small geometry
    while (queued_items < 800) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 9))
          0: set_geometry($urandom_range(0, 1), $urandom_range(0, 31));
          1: set_geometry($urandom_range(2, 12), $urandom_range(0, 1));
          2: set_geometry($urandom_range(65, 127), 1);
          default: set_geometry($urandom_range(2, 8), $urandom_range(1, 4));
        endcase
      end
      run_load($urandom_range(0, 2));
    end

    // largest geometry once, clamped from over-range counts
    set_geometry(127, 31);
    queue_load(STORE_DEPTH, 2);
    wait_drained();

    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

>>> warp_pairwise_violation_check.f
hdl/warp_pkg.sv
hdl/warp_ram.sv
hdl/warp_loader.sv
hdl/warp_scanner.sv
hdl/warp_pairwise_violation_check.sv
hdl/warp_checker.sv
tb/sv/tb_warp_pairwise_violation_check.sv
